FILE: design/pkcf_pkg.sv
// Shared types, constants and codes for the per-key chatter filter.
package pkcf_pkg;

   localparam int KEYS       = 128;
   localparam int TIME_BITS  = 32;
   localparam int KEY_W      = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int DELAY_BITS = 16;
   localparam int ELAP_W     = (TIME_BITS > DELAY_BITS) ? TIME_BITS : DELAY_BITS;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] KBD_INTERNAL_A = 8'd58;
   localparam logic [7:0] KBD_INTERNAL_B = 8'd59;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_BYPASS_ALL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_EXTERNAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_INTERNAL = 2'd2;

   localparam logic       OP_EVENT  = 1'b0;
   localparam logic       OP_LOAD   = 1'b1;
   localparam logic [1:0] KIND_DOWN = 2'd0;
   localparam logic [1:0] KIND_UP   = 2'd1;

   localparam logic [2:0] VERDICT_BYPASS      = 3'd0;
   localparam logic [2:0] VERDICT_ACCEPT      = 3'd1;
   localparam logic [2:0] VERDICT_BOUNCE_UP   = 3'd2;
   localparam logic [2:0] VERDICT_BOUNCE_DOWN = 3'd3;
   localparam logic [2:0] VERDICT_LOAD        = 3'd4;

   typedef logic [TIME_BITS-1:0]  time_type;
   typedef logic [KEY_W-1:0]      key_type;
   typedef logic [DELAY_BITS-1:0] delay_type;

   typedef enum logic [2:0] {
      CLS_LOAD,
      CLS_LOAD_SKIP,
      CLS_BYPASS,
      CLS_DOWN,
      CLS_UP,
      CLS_OTHER
   } cls_type;

   typedef struct packed {
      logic       op;
      logic [7:0] key_code;
      logic [1:0] event_kind;
      logic       auto_repeat;
      logic [7:0] keyboard_type;
      logic [31:0] time_ms;
      logic [15:0] set_delay_ms;
      logic       set_enabled;
   } req_type;

   typedef struct packed {
      logic        pass_event;
      logic [2:0]  verdict;
      logic [15:0] since_ms;
   } rsp_type;

   typedef struct packed {
      cls_type   cls;
      key_type   key;
      time_type  now;
      delay_type delay;
      logic      enable;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type work;
   } work_head_type;

endpackage

FILE: design/pkcf_front.sv
// Front end: configuration registers, event classification and the work queue.
module pkcf_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  pkcf_pkg::req_type                  req_data,
   input  logic                               csr_wen,
   input  logic [pkcf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic                               csr_wdata,
   output pkcf_pkg::work_head_type            work_head,
   input  logic                               work_pop
);
   import pkcf_pkg::*;

   logic bypass_all_ff, bypass_all_in;
   logic ignore_ext_ff, ignore_ext_in;
   logic ignore_int_ff, ignore_int_in;

   work_type q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] q_cnt_ff, q_cnt_in;

   logic     push_ok;
   logic     pop_ok;
   logic     internal;
   logic     ignored;
   logic     in_range;
   work_type new_work;

   always_comb begin
      bypass_all_in = bypass_all_ff;
      ignore_ext_in = ignore_ext_ff;
      ignore_int_in = ignore_int_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_BYPASS_ALL:    bypass_all_in = csr_wdata;
            CSR_SKIP_EXTERNAL: ignore_ext_in = csr_wdata;
            CSR_SKIP_INTERNAL: ignore_int_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // classify once here so the back end only sees what it must act on
   always_comb begin
      internal = (req_data.keyboard_type == KBD_INTERNAL_A) ||
                 (req_data.keyboard_type == KBD_INTERNAL_B);
      ignored  = bypass_all_ff || (ignore_ext_ff && !internal) ||
                 (ignore_int_ff && internal);
      in_range = {1'b0, req_data.key_code} < 9'(KEYS);

      new_work.key    = req_data.key_code[KEY_W-1:0];
      new_work.now    = time_type'(req_data.time_ms);
      new_work.delay  = req_data.set_delay_ms;
      new_work.enable = req_data.set_enabled;

      if (req_data.op == OP_LOAD) begin
         new_work.cls = in_range ? CLS_LOAD : CLS_LOAD_SKIP;
      end else if (ignored || !in_range ||
                   (req_data.event_kind == KIND_DOWN && req_data.auto_repeat)) begin
         new_work.cls = CLS_BYPASS;
      end else begin
         case (req_data.event_kind)
            KIND_DOWN: new_work.cls = CLS_DOWN;
            KIND_UP:   new_work.cls = CLS_UP;
            default:   new_work.cls = CLS_OTHER;
         endcase
      end
   end

   assign req_full = (q_cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = work_pop && (q_cnt_ff != '0);

   assign work_head.valid = (q_cnt_ff != '0);
   assign work_head.work  = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      q_cnt_in  = q_cnt_ff;
      if (push_ok && !pop_ok) begin
         q_cnt_in = q_cnt_ff + QCNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         q_cnt_in = q_cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_all_ff <= 1'b0;
         ignore_ext_ff <= 1'b0;
         ignore_int_ff <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         q_cnt_ff      <= '0;
      end else begin
         bypass_all_ff <= bypass_all_in;
         ignore_ext_ff <= ignore_ext_in;
         ignore_int_ff <= ignore_int_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         q_cnt_ff      <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_mem_ff[wr_ptr_ff] <= new_work;
      end
   end

   a_q_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("work queue count beyond depth");

   a_q_push_counts: assert property (@(posedge clock) disable iff (reset)
      (push_ok && !pop_ok) |=> (q_cnt_ff == $past(q_cnt_ff) + QCNT_W'(1)))
      else $error("accepted beat not counted in work queue");

   a_q_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      work_pop |-> work_head.valid)
      else $error("work queue popped while empty");

endmodule

FILE: design/pkcf_back.sv
// Back end: per-key tables, debounce decision and the result queue.
module pkcf_back (
   input  logic                     clock,
   input  logic                     reset,
   input  pkcf_pkg::work_head_type  work_head,
   output logic                     work_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output pkcf_pkg::rsp_type        rsp_data
);
   import pkcf_pkg::*;

   // per-key times and delays live in RAM; flags in flip-flops
   time_type  up_time_mem   [KEYS];
   time_type  down_time_mem [KEYS];
   delay_type delay_mem     [KEYS];

   logic [KEYS-1:0] key_on_ff, key_on_in;
   logic [KEYS-1:0] up_seen_ff, up_seen_in;
   logic [KEYS-1:0] down_seen_ff, down_seen_in;

   logic      b_valid_ff, b_valid_in;
   work_type  b_work_ff;
   time_type  up_time_rd_ff;
   time_type  down_time_rd_ff;
   delay_type delay_rd_ff;

   rsp_type           out_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] out_wr_ptr_ff, out_wr_ptr_in;
   logic [QPTR_W-1:0] out_rd_ptr_ff, out_rd_ptr_in;
   logic [QCNT_W-1:0] out_cnt_ff, out_cnt_in;

   key_type  k;
   logic     filtered;
   time_type el_up;
   time_type el_down;
   logic     up_hit;
   logic     down_hit;
   logic     wr_up;
   logic     wr_down;
   logic     wr_load;
   rsp_type  res;
   logic     out_room;
   logic     b_fire;
   logic     a_take;
   logic     out_pop;

   assign k        = b_work_ff.key;
   assign out_room = (out_cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign b_fire   = b_valid_ff && out_room;
   assign a_take   = work_head.valid && (!b_valid_ff || b_fire);
   assign work_pop = a_take;
   assign out_pop  = rsp_pop && !rsp_empty;

   always_comb begin
      filtered = key_on_ff[k] && (delay_rd_ff != '0);
      el_up    = b_work_ff.now - up_time_rd_ff;
      el_down  = b_work_ff.now - down_time_rd_ff;
      up_hit   = up_seen_ff[k] && (ELAP_W'(el_up) < ELAP_W'(delay_rd_ff));
      down_hit = down_seen_ff[k] && (ELAP_W'(el_down) < ELAP_W'(delay_rd_ff));

      res.pass_event = 1'b1;
      res.verdict    = VERDICT_BYPASS;
      res.since_ms   = '0;
      wr_up   = 1'b0;
      wr_down = 1'b0;
      wr_load = 1'b0;

      case (b_work_ff.cls)
         CLS_LOAD: begin
            res.pass_event = 1'b0;
            res.verdict    = VERDICT_LOAD;
            wr_load        = 1'b1;
         end
         CLS_LOAD_SKIP: begin
            res.pass_event = 1'b0;
            res.verdict    = VERDICT_LOAD;
         end
         CLS_DOWN: begin
            if (filtered) begin
               if (up_hit) begin
                  // elapsed is below the 16-bit delay, so it never saturates
                  res.pass_event = 1'b0;
                  res.verdict    = VERDICT_BOUNCE_UP;
                  res.since_ms   = 16'(el_up);
               end else if (down_hit) begin
                  res.pass_event = 1'b0;
                  res.verdict    = VERDICT_BOUNCE_DOWN;
                  res.since_ms   = 16'(el_down);
               end else begin
                  res.verdict = VERDICT_ACCEPT;
                  wr_down     = 1'b1;
               end
            end
         end
         CLS_UP: begin
            if (filtered) begin
               res.verdict = VERDICT_ACCEPT;
               wr_up       = 1'b1;
            end
         end
         CLS_OTHER: begin
            if (filtered) begin
               res.verdict = VERDICT_ACCEPT;
            end
         end
         default: ;
      endcase

      wr_up   = wr_up && b_fire;
      wr_down = wr_down && b_fire;
      wr_load = wr_load && b_fire;
   end

   always_comb begin
      key_on_in    = key_on_ff;
      up_seen_in   = up_seen_ff;
      down_seen_in = down_seen_ff;
      if (wr_load) begin
         key_on_in[k] = b_work_ff.enable;
      end
      if (wr_up) begin
         up_seen_in[k] = 1'b1;
      end
      if (wr_down) begin
         down_seen_in[k] = 1'b1;
      end
      b_valid_in = a_take || (b_valid_ff && !b_fire);
   end

   // result queue
   assign rsp_empty = (out_cnt_ff == '0);
   assign rsp_data  = out_mem_ff[out_rd_ptr_ff];

   always_comb begin
      out_wr_ptr_in = b_fire  ? out_wr_ptr_ff + QPTR_W'(1) : out_wr_ptr_ff;
      out_rd_ptr_in = out_pop ? out_rd_ptr_ff + QPTR_W'(1) : out_rd_ptr_ff;
      out_cnt_in    = out_cnt_ff;
      if (b_fire && !out_pop) begin
         out_cnt_in = out_cnt_ff + QCNT_W'(1);
      end else if (out_pop && !b_fire) begin
         out_cnt_in = out_cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_on_ff     <= '0;
         up_seen_ff    <= '0;
         down_seen_ff  <= '0;
         b_valid_ff    <= 1'b0;
         out_wr_ptr_ff <= '0;
         out_rd_ptr_ff <= '0;
         out_cnt_ff    <= '0;
      end else begin
         key_on_ff     <= key_on_in;
         up_seen_ff    <= up_seen_in;
         down_seen_ff  <= down_seen_in;
         b_valid_ff    <= b_valid_in;
         out_wr_ptr_ff <= out_wr_ptr_in;
         out_rd_ptr_ff <= out_rd_ptr_in;
         out_cnt_ff    <= out_cnt_in;
      end
   end

   // table writes, and reads for the next item with same-key forwarding
   always_ff @(posedge clock) begin
      if (wr_up) begin
         up_time_mem[k] <= b_work_ff.now;
      end
      if (wr_down) begin
         down_time_mem[k] <= b_work_ff.now;
      end
      if (wr_load) begin
         delay_mem[k] <= b_work_ff.delay;
      end
      if (a_take) begin
         b_work_ff <= work_head.work;
         up_time_rd_ff <= (wr_up && k == work_head.work.key) ?
                          b_work_ff.now : up_time_mem[work_head.work.key];
         down_time_rd_ff <= (wr_down && k == work_head.work.key) ?
                            b_work_ff.now : down_time_mem[work_head.work.key];
         delay_rd_ff <= (wr_load && k == work_head.work.key) ?
                        b_work_ff.delay : delay_mem[work_head.work.key];
      end
      if (b_fire) begin
         out_mem_ff[out_wr_ptr_ff] <= res;
      end
   end

   a_out_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue count beyond depth");

   a_pass_no_elapsed: assert property (@(posedge clock) disable iff (reset)
      (b_fire && res.pass_event) |-> (res.since_ms == '0))
      else $error("passed event carries elapsed time");

   a_suppress_verdict: assert property (@(posedge clock) disable iff (reset)
      (b_fire && !res.pass_event) |->
         (res.verdict == VERDICT_LOAD || res.verdict == VERDICT_BOUNCE_UP ||
          res.verdict == VERDICT_BOUNCE_DOWN))
      else $error("suppressed result with a passing verdict");

   a_up_forward: assert property (@(posedge clock) disable iff (reset)
      (a_take && wr_up && k == work_head.work.key) |=>
         (up_time_rd_ff == $past(b_work_ff.now)))
      else $error("key-up time not forwarded to same-key follower");

endmodule

FILE: design/per_key_chatter_filter_unit.sv
// Top level of the per-key keyboard chatter filter.
//
// Input: beats arrive on req_data with req_push; a beat is taken when req_full
// is low. A beat either filters one key event or (op set) loads one key's
// enable flag and debounce delay into the per-key table.
// Output: every input beat gives exactly one result beat on rsp_data, in
// order; it is offered while rsp_empty is low and taken with rsp_pop.
// Configuration: csr_wen writes csr_wdata into the register csr_index
// (bypass all, ignore external keyboards, ignore internal keyboards); write
// only while no beat is in flight.
// Path: work queue, back stage register, result queue. Throughput: one beat
// per cycle while rsp_pop is high, set by the single table read-modify-write
// in the back stage, with same-key forwarding from the write to the next read.
// Reset: configuration clears, every key reads as disabled and with no
// recorded down or up time; no clearing pass, beats are taken at once.
// Stall: with rsp_pop low the result queue (two beats), the back stage and
// the work queue (two beats) fill, then req_full rises; nothing is lost.
module per_key_chatter_filter_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  pkcf_pkg::req_type              req_data,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output pkcf_pkg::rsp_type              rsp_data,
   input  logic                           csr_wen,
   input  logic [pkcf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic                           csr_wdata
);
   import pkcf_pkg::*;

   work_head_type work_head;
   logic          work_pop;

   pkcf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .work_head (work_head),
      .work_pop  (work_pop)
   );

   pkcf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .work_head (work_head),
      .work_pop  (work_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: dv/chatter_verdict_checker.sv
// Checker for the per-key chatter filter: predicts each verdict and compares result beats.
`timescale 1ns / 100ps

module chatter_verdict_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic                           req_full,
   input  pkcf_pkg::req_type              req_data,
   input  logic                           rsp_empty,
   input  logic                           rsp_pop,
   input  pkcf_pkg::rsp_type              rsp_data,
   input  logic                           csr_wen,
   input  logic [pkcf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic                           csr_wdata,
   output int unsigned                    failures,
   output int unsigned                    pending
);
   import pkcf_pkg::*;

   logic bypass_all_q;
   logic ignore_ext_q;
   logic ignore_int_q;

   logic      key_enabled [KEYS];
   delay_type key_delay_ms [KEYS];
   logic      up_seen [KEYS];
   logic      down_seen [KEYS];
   time_type  up_stamp [KEYS];
   time_type  down_stamp [KEYS];

   rsp_type     verdict_q [$];
   int unsigned mismatch_count = 0;

   // Work out the verdict for one input beat and update the per-key history.
   function automatic rsp_type judge_event(input req_type beat);
      rsp_type  v;
      int       k;
      logic     internal;
      time_type now;
      time_type gap;

      v.pass_event = 1'b1;
      v.verdict    = VERDICT_BYPASS;
      v.since_ms   = '0;
      k   = int'(beat.key_code);
      now = time_type'(beat.time_ms);

      if (beat.op == OP_LOAD) begin
         if (k < KEYS) begin
            key_enabled[k]  = beat.set_enabled;
            key_delay_ms[k] = beat.set_delay_ms;
         end
         v.pass_event = 1'b0;
         v.verdict    = VERDICT_LOAD;
         return v;
      end

      internal = (beat.keyboard_type == KBD_INTERNAL_A) ||
                 (beat.keyboard_type == KBD_INTERNAL_B);
      if (bypass_all_q || (ignore_ext_q && !internal) || (ignore_int_q && internal))
         return v;
      if (k >= KEYS)
         return v;
      if (!key_enabled[k] || key_delay_ms[k] == '0)
         return v;

      v.verdict = VERDICT_ACCEPT;
      if (beat.event_kind == KIND_DOWN) begin
         if (beat.auto_repeat) begin
            v.verdict = VERDICT_BYPASS;
            return v;
         end
         if (up_seen[k]) begin
            gap = now - up_stamp[k];
            if (gap < time_type'(key_delay_ms[k])) begin
               v.pass_event = 1'b0;
               v.verdict    = VERDICT_BOUNCE_UP;
               v.since_ms   = (gap > time_type'(16'hFFFF)) ? 16'hFFFF : gap[15:0];
               return v;
            end
         end
         if (down_seen[k]) begin
            gap = now - down_stamp[k];
            if (gap < time_type'(key_delay_ms[k])) begin
               v.pass_event = 1'b0;
               v.verdict    = VERDICT_BOUNCE_DOWN;
               v.since_ms   = (gap > time_type'(16'hFFFF)) ? 16'hFFFF : gap[15:0];
               return v;
            end
         end
         down_stamp[k] = now;
         down_seen[k]  = 1'b1;
      end else if (beat.event_kind == KIND_UP) begin
         up_stamp[k] = now;
         up_seen[k]  = 1'b1;
      end
      return v;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;

      if (reset) begin
         bypass_all_q <= 1'b0;
         ignore_ext_q <= 1'b0;
         ignore_int_q <= 1'b0;
         for (int i = 0; i < KEYS; i++) begin
            key_enabled[i]  = 1'b0;
            key_delay_ms[i] = '0;
            up_seen[i]      = 1'b0;
            down_seen[i]    = 1'b0;
            up_stamp[i]     = '0;
            down_stamp[i]   = '0;
         end
         verdict_q.delete();
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_BYPASS_ALL:    bypass_all_q <= csr_wdata;
               CSR_SKIP_EXTERNAL: ignore_ext_q <= csr_wdata;
               CSR_SKIP_INTERNAL: ignore_int_q <= csr_wdata;
               default: ;
            endcase
         end

         // check the outgoing beat before queueing this edge's prediction
         if (rsp_pop && !rsp_empty) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: unexpected result beat: pass %0d verdict %0d elapsed %0d",
                        $time, rsp_data.pass_event, rsp_data.verdict, rsp_data.since_ms);
               mismatch_count++;
            end else begin
               want = verdict_q.pop_front();
               if (rsp_data.pass_event !== want.pass_event ||
                   rsp_data.verdict    !== want.verdict    ||
                   rsp_data.since_ms   !== want.since_ms) begin
                  $display("%0t: result mismatch: expected pass %0d verdict %0d elapsed %0d, %s",
                           $time, want.pass_event, want.verdict, want.since_ms,
                           $sformatf("actual pass %0d verdict %0d elapsed %0d",
                                     rsp_data.pass_event, rsp_data.verdict,
                                     rsp_data.since_ms));
                  mismatch_count++;
               end
            end
         end

         if (req_push && !req_full)
            verdict_q.push_back(judge_event(req_data));
      end

      pending  <= verdict_q.size();
      failures <= mismatch_count;
   end

endmodule

FILE: dv/tb_per_key_chatter_filter_unit.sv
// Testbench top for the per-key chatter filter: clock, reset, beat stimulus and verdict.
`timescale 1ns / 100ps

module tb_per_key_chatter_filter_unit;
   import pkcf_pkg::*;

   localparam logic [1:0]  KIND_OTHER    = 2'd2;
   localparam logic [1:0]  KIND_SPARE    = 2'd3;
   localparam int          POOL          = 4;
   localparam int          PHASES        = 7;
   localparam int          PHASE_ITEMS   = 90;
   localparam int unsigned STALL_LIMIT   = 2000;
   // {bypass all, skip external, skip internal} for each random phase
   localparam logic [2:0]  CFG_PLAN [0:PHASES-1] =
      '{3'b000, 3'b010, 3'b001, 3'b000, 3'b100, 3'b111, 3'b000};

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_push;
   logic                 req_full;
   req_type              req_data;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_wen;
   logic [CSR_IDX_W-1:0] csr_index;
   logic                 csr_wdata;

   int unsigned failures;
   int unsigned pending;
   int unsigned send_idle_pct = 9;
   int unsigned pop_idle_pct  = 58;
   int unsigned stall_cycles  = 0;

   logic [7:0]  pool_key [POOL];
   int unsigned pool_delay [POOL];
   logic [31:0] stamp_ms;

   always #5ns clock = ~clock;

   per_key_chatter_filter_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   chatter_verdict_checker checker_i (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .failures  (failures),
      .pending   (pending)
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_per_key_chatter_filter_unit NOT OK");
            $finish;
         end
      end
   end

   function automatic req_type key_event(input logic [7:0] key, input logic [1:0] kind,
                                         input logic rep, input logic [7:0] kbd,
                                         input logic [31:0] at_ms);
      req_type r;
      r.op            = OP_EVENT;
      r.key_code      = key;
      r.event_kind    = kind;
      r.auto_repeat   = rep;
      r.keyboard_type = kbd;
      r.time_ms       = at_ms;
      r.set_delay_ms  = 16'($urandom);
      r.set_enabled   = 1'($urandom);
      return r;
   endfunction

   function automatic req_type table_load(input logic [7:0] key, input logic en,
                                          input logic [15:0] dly);
      req_type r;
      r.op            = OP_LOAD;
      r.key_code      = key;
      r.event_kind    = 2'($urandom);
      r.auto_repeat   = 1'($urandom);
      r.keyboard_type = 8'($urandom);
      r.time_ms       = $urandom;
      r.set_delay_ms  = dly;
      r.set_enabled   = en;
      return r;
   endfunction

   function automatic int unsigned pick_delay();
      int unsigned roll;
      roll = $urandom_range(19);
      if (roll == 0) return 65535;
      if (roll == 1) return 1;
      return $urandom_range(3000, 2);
   endfunction

   // Hold the beat until it is taken; idle before it at the sender's rate.
   task automatic send(input req_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic set_config(input logic byp, input logic ext, input logic intl);
      csr_wen   <= 1'b1;
      csr_index <= CSR_BYPASS_ALL;
      csr_wdata <= byp;
      @(posedge clock);
      csr_index <= CSR_SKIP_EXTERNAL;
      csr_wdata <= ext;
      @(posedge clock);
      csr_index <= CSR_SKIP_INTERNAL;
      csr_wdata <= intl;
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // Wait until every predicted result beat has been taken.
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic random_item();
      int unsigned pick;
      int unsigned slot;
      int unsigned span;
      int unsigned roll;
      logic [1:0]  kind;
      logic [7:0]  kbd;

      pick = $urandom_range(99);
      slot = $urandom_range(POOL - 1);
      span = pool_delay[slot];
      if (pick < 70) begin
         roll = $urandom_range(99);
         if (roll < 45)      kind = KIND_DOWN;
         else if (roll < 88) kind = KIND_UP;
         else                kind = ($urandom_range(1) != 0) ? KIND_OTHER : KIND_SPARE;
         // land on the delay boundary now and then
         roll = $urandom_range(9);
         if (roll == 0)                   stamp_ms += span;
         else if (roll == 1 && span != 0) stamp_ms += span - 1;
         else                             stamp_ms += $urandom_range(2 * span);
         roll = $urandom_range(9);
         if (roll < 4)      kbd = KBD_INTERNAL_A;
         else if (roll < 7) kbd = KBD_INTERNAL_B;
         else               kbd = 8'($urandom_range(255));
         send(key_event(pool_key[slot], kind, $urandom_range(9) == 0, kbd, stamp_ms));
      end else if (pick < 80) begin
         pool_delay[slot] = ($urandom_range(9) == 0) ? 0 : pick_delay();
         send(table_load(pool_key[slot], $urandom_range(7) != 0, 16'(pool_delay[slot])));
      end else if (pick < 90) begin
         send(key_event(8'($urandom), 2'($urandom), 1'($urandom), 8'($urandom), $urandom));
      end else begin
         send(table_load(8'($urandom), 1'($urandom), 16'($urandom)));
      end
   endtask

   initial begin : stimulus
      reset     = 1'b1;
      req_push  = 1'b0;
      req_data  = '0;
      csr_wen   = 1'b0;
      csr_index = CSR_BYPASS_ALL;
      csr_wdata = 1'b0;
      stamp_ms  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      set_config(1'b0, 1'b0, 1'b0);

      // out-of-range key: the load is dropped and the event bypasses
      send(table_load(8'd255, 1'b1, 16'hFFFF));
      send(key_event(8'd255, KIND_DOWN, 1'b0, KBD_INTERNAL_A, 32'h0));
      send(key_event(8'd128, KIND_DOWN, 1'b0, KBD_INTERNAL_B, 32'h0));
      // key 0: down bounce across the time wrap, autorepeat, bounce after up
      send(table_load(8'd0, 1'b1, 16'd100));
      send(key_event(8'd0, KIND_DOWN, 1'b0, KBD_INTERNAL_A, 32'hFFFF_FFC0));
      send(key_event(8'd0, KIND_DOWN, 1'b0, KBD_INTERNAL_A, 32'd10));
      send(key_event(8'd0, KIND_DOWN, 1'b1, KBD_INTERNAL_A, 32'd12));
      send(key_event(8'd0, KIND_UP, 1'b0, KBD_INTERNAL_B, 32'd20));
      send(key_event(8'd0, KIND_DOWN, 1'b0, 8'd0, 32'd119));
      send(key_event(8'd0, KIND_DOWN, 1'b0, 8'd0, 32'd120));
      send(key_event(8'd0, KIND_OTHER, 1'b0, 8'd0, 32'd121));
      send(key_event(8'd0, KIND_SPARE, 1'b1, 8'd255, 32'd122));
      // key 127 with the longest delay
      send(table_load(8'd127, 1'b1, 16'hFFFF));
      send(key_event(8'd127, KIND_UP, 1'b0, 8'd255, 32'hFFFF_FFFF));
      send(key_event(8'd127, KIND_DOWN, 1'b0, 8'd255, 32'd65533));
      send(key_event(8'd127, KIND_DOWN, 1'b0, 8'd255, 32'd65534));
      // disabled key, then zero delay
      send(table_load(8'd1, 1'b0, 16'd500));
      send(key_event(8'd1, KIND_DOWN, 1'b0, KBD_INTERNAL_A, 32'd1000));
      send(table_load(8'd2, 1'b1, 16'd0));
      send(key_event(8'd2, KIND_DOWN, 1'b0, KBD_INTERNAL_A, 32'd1000));
      send(key_event(8'd2, KIND_UP, 1'b0, KBD_INTERNAL_A, 32'd1001));
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase < 2) begin
            send_idle_pct = 9;
            pop_idle_pct  = 58;
         end else if (phase < 5) begin
            send_idle_pct = 58;
            pop_idle_pct  = 9;
         end else begin
            send_idle_pct = 0;
            pop_idle_pct  = 0;
         end
         set_config(CFG_PLAN[phase][2], CFG_PLAN[phase][1], CFG_PLAN[phase][0]);
         stamp_ms = $urandom;
         for (int i = 0; i < POOL; i++) begin
            pool_key[i]   = 8'($urandom_range(KEYS - 1));
            pool_delay[i] = pick_delay();
            send(table_load(pool_key[i], 1'b1, 16'(pool_delay[i])));
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            random_item();
         end
         settle();
      end

      if (failures == 0) begin
         $display("tb_per_key_chatter_filter_unit OK");
      end else begin
         $display("tb_per_key_chatter_filter_unit NOT OK");
      end
      $finish;
   end

endmodule
